// ===== rtl/lurr_pkg.sv =====
// lurr_pkg: shared widths, memory type codes and helpers for the largest usable
// ram run block. Used by largest_usable_ram_run, lurr_align and lurr_checker.
// No dependencies.
package lurr_pkg;

  // descriptor field widths
  localparam int MEM_TYPE_W  = 32;
  localparam int PHYS_W      = 48;
  localparam int PAGES_W     = 37;

  // result field widths
  localparam int OUT_ADDR_W  = 48;
  localparam int TOTAL_W     = 52;

  // packed stream widths, padded to whole bytes
  localparam int IN_FIELDS_W  = MEM_TYPE_W + PHYS_W + PAGES_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = OUT_ADDR_W + OUT_ADDR_W + TOTAL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = '1;
  localparam logic [OUT_ADDR_W-1:0] OUT_ADDR_MAX = '1;

  // memory type codes that count as usable ram
  localparam logic [MEM_TYPE_W-1:0] MT_LOADER_CODE        = 32'd1;
  localparam logic [MEM_TYPE_W-1:0] MT_LOADER_DATA        = 32'd2;
  localparam logic [MEM_TYPE_W-1:0] MT_BOOT_SERVICES_CODE = 32'd3;
  localparam logic [MEM_TYPE_W-1:0] MT_BOOT_SERVICES_DATA = 32'd4;
  localparam logic [MEM_TYPE_W-1:0] MT_RUNTIME_CODE       = 32'd5;
  localparam logic [MEM_TYPE_W-1:0] MT_RUNTIME_DATA       = 32'd6;
  localparam logic [MEM_TYPE_W-1:0] MT_CONVENTIONAL       = 32'd7;
  localparam logic [MEM_TYPE_W-1:0] MT_ACPI_RECLAIM       = 32'd9;
  localparam logic [MEM_TYPE_W-1:0] MT_ACPI_NVS           = 32'd10;

  function automatic logic mem_type_usable(input logic [MEM_TYPE_W-1:0] t);
    return (t == MT_LOADER_CODE)        || (t == MT_LOADER_DATA)  ||
           (t == MT_BOOT_SERVICES_CODE) || (t == MT_BOOT_SERVICES_DATA) ||
           (t == MT_RUNTIME_CODE)       || (t == MT_RUNTIME_DATA) ||
           (t == MT_CONVENTIONAL)       || (t == MT_ACPI_RECLAIM) ||
           (t == MT_ACPI_NVS);
  endfunction

endpackage

// ===== rtl/largest_usable_ram_run.sv =====
// largest_usable_ram_run: top level, scans memory map descriptors for the
// longest contiguous usable ram run. Depends on lurr_pkg and lurr_align.
//
// usage:
//   descriptors enter on the in_ stream, one item per cycle while in_tready is high; in_tlast marks
//   the final descriptor of a map. one result item leaves on the out_ stream
//   for each map, after its last descriptor: aligned base, aligned size and
//   the saturating total of usable bytes, with out_tuser flagging an empty
//   aligned run.
//   throughput: one descriptor per cycle while in_tready is high, set by the run
//   update (one length compare chain on the registered run and best-run state).
//   path: a result passes the input register, the snapshot register and the
//   result register after its last descriptor is accepted, and can be held in each.
//   reset: rst_n low clears the run state, the running total and all valid
//   flags; no result is pending afterwards.
//   stalls: a held result does not block the descriptors of the next map;
//   only a second last descriptor waits while both the snapshot and the
//   result register are occupied, and then in_tready drops.
module largest_usable_ram_run #(
  parameter int ADDR_BITS   = 48,
  parameter int ALIGN_SHIFT = 21,
  parameter int PAGE_SHIFT  = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // mem_type [31:0], phys_start [79:32], page_count [116:80], zero pad above
  input  logic [lurr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tlast,   // is_last
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // ram_base [47:0], ram_size [95:48], total_bytes [147:96], zero pad above
  output logic [lurr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // no_aligned_run [0]
  output logic [0:0]                         out_tuser
);

  localparam int AW        = ADDR_BITS;
  localparam int LW        = ADDR_BITS + 1;
  localparam int LEN_W     = lurr_pkg::PAGES_W + PAGE_SHIFT;
  localparam int END_W     = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int SUM_W     = ((lurr_pkg::TOTAL_W > LEN_W) ? lurr_pkg::TOTAL_W : LEN_W) + 1;
  localparam int START_SEL = (AW < lurr_pkg::PHYS_W) ? AW : lurr_pkg::PHYS_W;
  localparam int TYPE_LO   = 0;
  localparam int START_LO  = lurr_pkg::MEM_TYPE_W;
  localparam int PAGES_LO  = START_LO + lurr_pkg::PHYS_W;
  localparam int OUT_PAD   = lurr_pkg::OUT_TDATA_W - lurr_pkg::OUT_FIELDS_W;

  // input register
  logic                                s1_v_r;
  logic [lurr_pkg::MEM_TYPE_W-1:0]     s1_type_r;
  logic [lurr_pkg::PHYS_W-1:0]         s1_start_r;
  logic [lurr_pkg::PAGES_W-1:0]        s1_pages_r;
  logic                                s1_last_r;

  // run state
  logic [AW-1:0]                       run_first_r, run_first_nxt;
  logic [LW-1:0]                       run_limit_r, run_limit_nxt;
  logic                                run_open_r,  run_open_nxt;
  logic [AW-1:0]                       best_first_r, best_first_nxt;
  logic [LW-1:0]                       best_limit_r, best_limit_nxt;
  logic [lurr_pkg::TOTAL_W-1:0]        usable_sum_r, usable_sum_nxt;

  // snapshot of a finished map
  logic                                snap_v_r;
  logic [AW-1:0]                       snap_first_r;
  logic [LW-1:0]                       snap_limit_r;
  logic [lurr_pkg::TOTAL_W-1:0]        snap_sum_r;

  // result register
  logic                                out_v_r;
  logic [lurr_pkg::OUT_ADDR_W-1:0]     out_base_r;
  logic [lurr_pkg::OUT_ADDR_W-1:0]     out_size_r;
  logic [lurr_pkg::TOTAL_W-1:0]        out_total_r;
  logic                                out_none_r;

  // handshake
  logic in_fire, s1_fire, out_free, snap_free, out_load;

  // descriptor decode and run update
  logic                                usable;
  logic [AW-1:0]                       start_a;
  logic [LEN_W-1:0]                    len;
  logic [END_W-1:0]                    end_full;
  logic [LW-1:0]                       end_sat;
  logic [SUM_W-1:0]                    sum_full;
  logic [lurr_pkg::TOTAL_W-1:0]        sum_sat;
  logic                                extend;
  logic [LW-1:0]                       run_len, best_len, new_len;
  logic                                close_old, close_fin;
  logic [AW-1:0]                       upd_first, mid_first, fin_first;
  logic [LW-1:0]                       upd_limit, mid_limit, fin_limit;
  logic                                upd_open;

  // aligned result
  logic [lurr_pkg::OUT_ADDR_W-1:0]     al_base, al_size;
  logic                                al_none;

  assign out_free  = !out_v_r || out_tready;
  assign snap_free = !snap_v_r || out_free;
  assign out_load  = snap_v_r && out_free;
  // a last descriptor needs a free snapshot slot; others always retire
  assign s1_fire   = s1_v_r && (!s1_last_r || snap_free);
  assign in_tready = !s1_v_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    usable   = lurr_pkg::mem_type_usable(s1_type_r);
    start_a  = AW'(s1_start_r[START_SEL-1:0]);
    len      = {s1_pages_r, {PAGE_SHIFT{1'b0}}};
    end_full = END_W'(start_a) + END_W'(len);
    end_sat  = (end_full > END_W'({LW{1'b1}})) ? {LW{1'b1}} : LW'(end_full);
    sum_full = SUM_W'(usable_sum_r) + SUM_W'(len);
    sum_sat  = (sum_full > SUM_W'(lurr_pkg::TOTAL_MAX)) ? lurr_pkg::TOTAL_MAX
                                                         : lurr_pkg::TOTAL_W'(sum_full);

    extend   = run_open_r && ({1'b0, start_a} == run_limit_r);
    run_len  = run_limit_r - {1'b0, run_first_r};
    best_len = best_limit_r - {1'b0, best_first_r};

    // a usable descriptor that does not continue the run closes it
    close_old = usable && !extend && run_open_r && (run_len > best_len);
    mid_first = close_old ? run_first_r : best_first_r;
    mid_limit = close_old ? run_limit_r : best_limit_r;

    if (usable) begin
      upd_first = extend ? run_first_r : start_a;
      upd_limit = end_sat;
      upd_open  = 1'b1;
    end else begin
      upd_first = run_first_r;
      upd_limit = run_limit_r;
      upd_open  = run_open_r;
    end

    // final close on the last descriptor, compared against both candidates
    new_len   = upd_limit - {1'b0, upd_first};
    close_fin = upd_open && (close_old ? (new_len > run_len) : (new_len > best_len));
    fin_first = close_fin ? upd_first : mid_first;
    fin_limit = close_fin ? upd_limit : mid_limit;

    run_first_nxt  = run_first_r;
    run_limit_nxt  = run_limit_r;
    run_open_nxt   = run_open_r;
    best_first_nxt = best_first_r;
    best_limit_nxt = best_limit_r;
    usable_sum_nxt = usable_sum_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        run_first_nxt  = '0;
        run_limit_nxt  = '0;
        run_open_nxt   = 1'b0;
        best_first_nxt = '0;
        best_limit_nxt = '0;
        usable_sum_nxt = '0;
      end else begin
        run_first_nxt  = upd_first;
        run_limit_nxt  = upd_limit;
        run_open_nxt   = upd_open;
        best_first_nxt = mid_first;
        best_limit_nxt = mid_limit;
        usable_sum_nxt = usable ? sum_sat : usable_sum_r;
      end
    end
  end

  lurr_align #(
    .ADDR_BITS   (ADDR_BITS),
    .ALIGN_SHIFT (ALIGN_SHIFT)
  ) u_align (
    .first_i (snap_first_r),
    .limit_i (snap_limit_r),
    .base_o  (al_base),
    .size_o  (al_size),
    .none_o  (al_none)
  );

  // control state and valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      snap_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      run_first_r  <= '0;
      run_limit_r  <= '0;
      run_open_r   <= 1'b0;
      best_first_r <= '0;
      best_limit_r <= '0;
      usable_sum_r <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
      if (s1_fire && s1_last_r) begin
        snap_v_r <= 1'b1;
      end else if (out_load) begin
        snap_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      run_first_r  <= run_first_nxt;
      run_limit_r  <= run_limit_nxt;
      run_open_r   <= run_open_nxt;
      best_first_r <= best_first_nxt;
      best_limit_r <= best_limit_nxt;
      usable_sum_r <= usable_sum_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type_r  <= in_tdata[TYPE_LO +: lurr_pkg::MEM_TYPE_W];
      s1_start_r <= in_tdata[START_LO +: lurr_pkg::PHYS_W];
      s1_pages_r <= in_tdata[PAGES_LO +: lurr_pkg::PAGES_W];
      s1_last_r  <= in_tlast;
    end
    if (s1_fire && s1_last_r) begin
      snap_first_r <= fin_first;
      snap_limit_r <= fin_limit;
      snap_sum_r   <= usable ? sum_sat : usable_sum_r;
    end
    if (out_load) begin
      out_base_r  <= al_base;
      out_size_r  <= al_size;
      out_total_r <= snap_sum_r;
      out_none_r  <= al_none;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_total_r, out_size_r, out_base_r};
  assign out_tuser  = out_none_r;

endmodule

// ===== rtl/lurr_align.sv =====
// lurr_align: rounds the best run inward to the alignment granule and
// saturates base and size to the result width. Depends on lurr_pkg.
module lurr_align #(
  parameter int ADDR_BITS   = 48,
  parameter int ALIGN_SHIFT = 21
) (
  input  logic [ADDR_BITS-1:0]              first_i,
  input  logic [ADDR_BITS:0]                limit_i,
  output logic [lurr_pkg::OUT_ADDR_W-1:0]   base_o,
  output logic [lurr_pkg::OUT_ADDR_W-1:0]   size_o,
  output logic                              none_o
);

  localparam int LW    = ADDR_BITS + 1;
  localparam int SAT_W = (LW > lurr_pkg::OUT_ADDR_W) ? LW : lurr_pkg::OUT_ADDR_W;
  localparam logic [LW-1:0] ALIGN_M1 = LW'((64'd1 << ALIGN_SHIFT) - 64'd1);

  logic [LW-1:0]    base_up;
  logic [LW-1:0]    base_al;
  logic [LW-1:0]    lim_al;
  logic [LW-1:0]    diff;
  logic [SAT_W-1:0] base_w;
  logic [SAT_W-1:0] size_w;

  always_comb begin
    base_up = {1'b0, first_i} + ALIGN_M1;
    base_al = base_up & ~ALIGN_M1;
    lim_al  = limit_i & ~ALIGN_M1;
    none_o  = !(lim_al > base_al);
    diff    = lim_al - base_al;
    base_w  = SAT_W'(base_al);
    size_w  = none_o ? '0 : SAT_W'(diff);
    base_o  = (base_w > SAT_W'(lurr_pkg::OUT_ADDR_MAX)) ? lurr_pkg::OUT_ADDR_MAX
                                                         : lurr_pkg::OUT_ADDR_W'(base_w);
    size_o  = (size_w > SAT_W'(lurr_pkg::OUT_ADDR_MAX)) ? lurr_pkg::OUT_ADDR_MAX
                                                         : lurr_pkg::OUT_ADDR_W'(size_w);
  end

endmodule

// ===== rtl/lurr_checker.sv =====
// lurr_checker: port-level assertions for largest_usable_ram_run, bound to the
// top level at the end of this file. Depends on lurr_pkg.
module lurr_assertions #(
  parameter int ALIGN_SHIFT = 21
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lurr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [0:0]                        out_tuser
);

  localparam int OW = lurr_pkg::OUT_ADDR_W;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // empty aligned run reports zero size
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[2*OW-1:OW] == '0)
    else $error("flagged empty run with nonzero size");

  // a non-empty aligned run has a size
  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[2*OW-1:OW] != '0)
    else $error("zero size without empty flag");

  // unsaturated base sits on the alignment granule
  a_base_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[OW-1:0] != lurr_pkg::OUT_ADDR_MAX)
      |-> out_tdata[ALIGN_SHIFT-1:0] == '0)
    else $error("base not aligned");

endmodule

bind largest_usable_ram_run lurr_assertions #(.ALIGN_SHIFT(ALIGN_SHIFT)) u_lurr_assertions (.*);
